// File: sv/skrt_pkg.sv
`timescale 1ns / 1ps
package skrt_pkg;

  localparam int DefCapacity = 64;
  localparam int WordW = 32;
  localparam int TotalW = 7;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_EDIT   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LOC    = 3'd3,
    OP_ID     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS_SHIFT,
    S_REM_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [WordW-1:0] id;
    logic [WordW-1:0] loc;
    logic [WordW-1:0] extra;
    logic [WordW-1:0] mult;
    logic [WordW-1:0] mode;
  } rec_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_start; // reset the scan pointer to zero
    logic scan_step;  // look at the record read last cycle
    logic ins_start;  // start an upward shift from the top
    logic ins_step;   // one move of the upward shift
    logic rem_start;  // start a downward shift at the hit slot
    logic rem_step;   // one move of the downward shift
    logic done;       // finish: write back count and present the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] op;
    logic       scan_end;  // scan reached the end of the table
    logic       hit;       // a match has been found
    logic       full;
    logic       shift_end; // current shift has finished
    logic       out_busy;  // output register still holds an untaken item
  } stat_t;

endpackage

// File: sv/skrt_datapath.sv
`timescale 1ns / 1ps
module skrt_datapath #(
  parameter int CAPACITY = skrt_pkg::DefCapacity
) (
  input  logic                       clk,
  input  logic                       rst,
  input  skrt_pkg::cmd_t             cmd,
  output skrt_pkg::stat_t            stat,
  input  logic [2:0]                 operation,
  input  logic [skrt_pkg::WordW-1:0] key_loc,
  input  logic [skrt_pkg::WordW-1:0] entry_id,
  input  logic [skrt_pkg::WordW-1:0] entry_extra,
  input  logic [skrt_pkg::WordW-1:0] entry_mult,
  input  logic [skrt_pkg::WordW-1:0] entry_mode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [skrt_pkg::WordW-1:0] found_id,
  output logic [skrt_pkg::WordW-1:0] found_loc,
  output logic [skrt_pkg::WordW-1:0] found_extra,
  output logic [skrt_pkg::WordW-1:0] found_mult,
  output logic [skrt_pkg::WordW-1:0] found_mode,
  output logic [skrt_pkg::TotalW-1:0] entry_total
);
  import skrt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  rec_t mem [CAPACITY];
  rec_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;

  logic [2:0]    op;
  rec_t          item;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;       // scan pointer: index of the record in rd_data
  logic          ptr_ok;    // rd_data holds record ptr
  logic          hit;
  logic          slot_set;
  logic [CW-1:0] hit_idx;
  logic [CW-1:0] slot_idx;
  rec_t          hit_rec;
  logic [CW-1:0] sh;        // shift position
  logic          sh_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic loc_match;
  logic id_match;
  assign loc_match = ptr_ok && (rd_data.loc == item.loc);
  assign id_match = ptr_ok && (rd_data.id == item.id);

  // Read address: scan walks upward; insert shift reads sh-1; remove reads sh+1.
  always_comb begin
    rd_addr = AW'(0);
    wr_en = 1'b0;
    wr_addr = AW'(0);
    wr_data = item;
    if (cmd.scan_start) begin
      rd_addr = AW'(0);
    end else if (cmd.scan_step) begin
      rd_addr = AW'(ptr + CW'(1));
    end else if (cmd.ins_start) begin
      rd_addr = AW'(count - CW'(1));
    end else if (cmd.ins_step) begin
      // rd_data holds record sh-1; write it to sh, read sh-2.
      if (sh > slot_idx) begin
        wr_en = 1'b1;
        wr_addr = AW'(sh);
        wr_data = rd_data;
        rd_addr = AW'(sh - CW'(2));
      end else begin
        wr_en = 1'b1;
        wr_addr = AW'(slot_idx);
        wr_data = item;
      end
    end else if (cmd.rem_start) begin
      rd_addr = AW'(hit_idx + CW'(1));
    end else if (cmd.rem_step) begin
      if (sh + CW'(1) < count) begin
        wr_en = 1'b1;
        wr_addr = AW'(sh);
        wr_data = rd_data;
        rd_addr = AW'(sh + CW'(2));
      end
    end else if (cmd.done && op == OP_EDIT && hit) begin
      wr_en = 1'b1;
      wr_addr = AW'(hit_idx);
      wr_data = item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.done) begin
        out_valid <= 1'b1;
        if (op == OP_INSERT && !hit && count < CW'(CAPACITY)) begin
          count <= count + CW'(1);
        end else if (op == OP_REMOVE && hit) begin
          count <= count - CW'(1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      item <= '{entry_id, key_loc, entry_extra, entry_mult, entry_mode};
    end
    if (cmd.scan_start) begin
      ptr <= '0;
      ptr_ok <= (count != '0);
      hit <= 1'b0;
      slot_set <= 1'b0;
      slot_idx <= count;
      hit_idx <= '0;
    end else if (cmd.scan_step) begin
      if (ptr_ok && !hit) begin
        if ((op == OP_ID) ? id_match : loc_match) begin
          hit <= 1'b1;
          hit_idx <= ptr;
          hit_rec <= rd_data;
        end
        if (!slot_set && !(rd_data.loc < item.loc)) begin
          slot_set <= 1'b1;
          slot_idx <= ptr;
        end
      end
      ptr <= ptr + CW'(1);
      ptr_ok <= (ptr + CW'(1) < count);
    end
    if (cmd.ins_start) begin
      sh <= count;
      sh_ok <= 1'b1;
    end else if (cmd.ins_step) begin
      sh <= sh - CW'(1);
      sh_ok <= (sh > slot_idx);
    end else if (cmd.rem_start) begin
      sh <= hit_idx;
      sh_ok <= 1'b1;
    end else if (cmd.rem_step) begin
      sh <= sh + CW'(1);
      sh_ok <= (sh + CW'(1) < count);
    end
    if (cmd.done) begin
      case (op)
        OP_INSERT: status <= hit ? ST_DUP : ((count >= CW'(CAPACITY)) ? ST_FULL : ST_OK);
        OP_EDIT, OP_REMOVE: status <= hit ? ST_OK : ST_NOTFOUND;
        OP_LOC, OP_ID: status <= hit ? ST_OK : ST_NOTFOUND;
        default: status <= ST_NOTFOUND;
      endcase
      if (hit && (op == OP_LOC || op == OP_ID)) begin
        found_id <= hit_rec.id;
        found_loc <= hit_rec.loc;
        found_extra <= hit_rec.extra;
        found_mult <= hit_rec.mult;
        found_mode <= hit_rec.mode;
      end else begin
        {found_id, found_loc, found_extra, found_mult, found_mode} <= '0;
      end
    end
  end

  // Count after the operation, written in the same edge as the status.
  logic [CW-1:0] count_after;
  always_comb begin
    count_after = count;
    if (op == OP_INSERT && !hit && count < CW'(CAPACITY)) begin
      count_after = count + CW'(1);
    end else if (op == OP_REMOVE && hit) begin
      count_after = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      entry_total <= TotalW'(count_after);
    end
  end

  assign stat.op = op;
  assign stat.scan_end = !ptr_ok;
  assign stat.hit = hit;
  assign stat.full = (count >= CW'(CAPACITY));
  assign stat.shift_end = !sh_ok;
  assign stat.out_busy = out_valid;
endmodule

// File: sv/skrt_ctrl.sv
`timescale 1ns / 1ps
module skrt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  input  skrt_pkg::stat_t stat,
  output skrt_pkg::cmd_t  cmd
);
  import skrt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // The scan pointer is cleared as the item is taken.
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // Stop early once found, except insert which also needs its slot.
        if (stat.scan_end || (stat.hit && stat.op != OP_INSERT)) begin
          if (stat.op == OP_INSERT && !stat.hit && !stat.full) begin
            cmd.ins_start = 1'b1;
            state_next = S_INS_SHIFT;
          end else if (stat.op == OP_REMOVE && stat.hit) begin
            cmd.rem_start = 1'b1;
            state_next = S_REM_SHIFT;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_INS_SHIFT: begin
        if (stat.shift_end) begin
          state_next = S_DONE;
        end else begin
          cmd.ins_step = 1'b1;
        end
      end
      S_REM_SHIFT: begin
        if (stat.shift_end) begin
          state_next = S_DONE;
        end else begin
          cmd.rem_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy || !out_stall) begin
          cmd.done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: sv/sorted_keyed_record_table.sv
`timescale 1ns / 1ps
// Sorted table of up to CAPACITY five-word records, kept in ascending order
// of location key.
// Input channel (in_valid/in_stall) carries one operation item: insert, edit,
// remove, lookup by location or lookup by id. Output channel
// (out_valid/out_stall) returns exactly one result item per operation:
// status, the found record (zero unless a lookup succeeds) and the count.
// One item at a time is processed. The record store is a single-port-write,
// single-read memory, so each operation walks it one record per cycle:
// a scan over the N records held, then for insert an upward shift and for
// remove a downward shift, plus a step to take the item and one to write
// the result. Lookups stop as soon as they hit.
// The result sits in an output register; a new item is taken while it
// waits, and the block only holds off finishing the next item while the
// receiver stalls an earlier result. Reset empties the table at once.
module sorted_keyed_record_table #(
  parameter int CAPACITY = skrt_pkg::DefCapacity
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  operation,
  input  logic [skrt_pkg::WordW-1:0]  key_loc,
  input  logic [skrt_pkg::WordW-1:0]  entry_id,
  input  logic [skrt_pkg::WordW-1:0]  entry_extra,
  input  logic [skrt_pkg::WordW-1:0]  entry_mult,
  input  logic [skrt_pkg::WordW-1:0]  entry_mode,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [skrt_pkg::WordW-1:0]  found_id,
  output logic [skrt_pkg::WordW-1:0]  found_loc,
  output logic [skrt_pkg::WordW-1:0]  found_extra,
  output logic [skrt_pkg::WordW-1:0]  found_mult,
  output logic [skrt_pkg::WordW-1:0]  found_mode,
  output logic [skrt_pkg::TotalW-1:0] entry_total
);
  import skrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  skrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  skrt_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .operation(operation), .key_loc(key_loc), .entry_id(entry_id),
    .entry_extra(entry_extra), .entry_mult(entry_mult), .entry_mode(entry_mode),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .found_id(found_id), .found_loc(found_loc), .found_extra(found_extra),
    .found_mult(found_mult), .found_mode(found_mode), .entry_total(entry_total)
  );
endmodule

// File: dv/skrt_checker.sv
`timescale 1ns / 1ps
module skrt_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] key_loc,
  input  logic [31:0] entry_id,
  input  logic [31:0] entry_extra,
  input  logic [31:0] entry_mult,
  input  logic [31:0] entry_mode,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [31:0] found_id,
  input  logic [31:0] found_loc,
  input  logic [31:0] found_extra,
  input  logic [31:0] found_mult,
  input  logic [31:0] found_mode,
  input  logic [6:0]  entry_total,
  output int          fail_count,
  output int          pending
);
  import skrt_pkg::*;

  typedef struct packed {
    status_t     st;
    rec_t        rec;
    logic [6:0]  total;
  } reply_t;

  rec_t   shadow[CAPACITY];
  int     held;
  reply_t replies[$];

  assign pending = replies.size();

  initial fail_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int index_of_loc(input logic [31:0] loc);
    int i;
    for (i = 0; i < held; i++) if (shadow[i].loc == loc) return i;
    return held;
  endfunction

  // Applies one operation to the shadow table and returns the reply it causes.
  function automatic reply_t apply_op(input logic [2:0] op, input rec_t r);
    reply_t res;
    int i, j;
    res = '0;
    res.st = ST_NOTFOUND;
    case (op)
      OP_INSERT: begin
        if (index_of_loc(r.loc) < held) res.st = ST_DUP;
        else if (held >= CAPACITY) res.st = ST_FULL;
        else begin
          i = 0;
          while (i < held && shadow[i].loc < r.loc) i++;
          for (j = held; j > i; j--) shadow[j] = shadow[j-1];
          shadow[i] = r;
          held++;
          res.st = ST_OK;
        end
      end
      OP_EDIT: begin
        i = index_of_loc(r.loc);
        if (i < held) begin
          shadow[i] = r;
          res.st = ST_OK;
        end
      end
      OP_REMOVE: begin
        i = index_of_loc(r.loc);
        if (i < held) begin
          for (j = i; j + 1 < held; j++) shadow[j] = shadow[j+1];
          held--;
          res.st = ST_OK;
        end
      end
      OP_LOC: begin
        i = index_of_loc(r.loc);
        if (i < held) begin
          res.rec = shadow[i];
          res.st = ST_OK;
        end
      end
      OP_ID: begin
        for (i = 0; i < held; i++) begin
          if (shadow[i].id == r.id) begin
            res.rec = shadow[i];
            res.st = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    res.total = held[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    rec_t r;
    if (rst) begin
      held = 0;
      replies.delete();
    end else begin
      if (in_valid && !in_stall) begin
        r.id = entry_id;
        r.loc = key_loc;
        r.extra = entry_extra;
        r.mult = entry_mult;
        r.mode = entry_mode;
        replies.push_back(apply_op(operation, r));
      end
      if (out_valid && !out_stall) begin
        if (replies.size() == 0) begin
          $display("%0t result with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = replies.pop_front();
          if (status != want.st) report("status", 32'(status), 32'(want.st));
          if (found_id != want.rec.id) report("found_id", found_id, want.rec.id);
          if (found_loc != want.rec.loc) report("found_loc", found_loc, want.rec.loc);
          if (found_extra != want.rec.extra)
            report("found_extra", found_extra, want.rec.extra);
          if (found_mult != want.rec.mult) report("found_mult", found_mult, want.rec.mult);
          if (found_mode != want.rec.mode) report("found_mode", found_mode, want.rec.mode);
          if (entry_total != want.total)
            report("entry_total", 32'(entry_total), 32'(want.total));
        end
      end
    end
  end
endmodule

// File: dv/tb_sorted_keyed_record_table.sv
`timescale 1ns / 1ps
module tb_sorted_keyed_record_table;
  import skrt_pkg::*;

  localparam int Cap = 64;
  localparam int StallLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [31:0] key_loc = '0, entry_id = '0, entry_extra = '0, entry_mult = '0;
  logic [31:0] entry_mode = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] found_id, found_loc, found_extra, found_mult, found_mode;
  logic [6:0]  entry_total;
  int          fail_count, pending;
  int          idle_cycles = 0;
  int          sent = 0, hits_full = 0;
  bit          stim_done = 1'b0;

  // Small pools make keys and ids collide often enough to hit every path.
  logic [31:0] loc_pool[16];
  logic [31:0] id_pool[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_keyed_record_table #(.CAPACITY(Cap)) dut (.*);

  skrt_checker #(.CAPACITY(Cap)) u_checker (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Valid stays high after an accept until the next negedge that either
  // drops it for a gap or presents the next item.
  task automatic send(input logic [2:0] op, input logic [31:0] loc, input logic [31:0] id);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    key_loc <= loc;
    entry_id <= id;
    entry_extra <= $urandom();
    entry_mult <= $urandom();
    entry_mode <= $urandom();
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [31:0] pick_loc();
    int p;
    p = $urandom_range(0, 9);
    if (p < 8) return loc_pool[$urandom_range(0, 15)];
    return $urandom();
  endfunction

  // Receiver stalls: bursts of stall, with long stretches of none.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (!(stim_done && pending == 0)) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("tb_sorted_keyed_record_table: errors");
      $finish;
    end
  end

  initial begin
    int n, op;
    logic [31:0] k;
    for (int i = 0; i < 16; i++) loc_pool[i] = $urandom();
    loc_pool[0] = 32'h0;
    loc_pool[1] = 32'hFFFF_FFFF;
    for (int i = 0; i < 8; i++) id_pool[i] = $urandom();
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: operations on an empty table, extremes, a duplicate, a miss
    // by id, two unknown codes, then lookups and removes by key, one of them a miss.
    send(OP_LOC, 32'h0, 32'h0);
    send(OP_ID, 32'h0, 32'h0);
    send(OP_EDIT, 32'h5, 32'h1);
    send(OP_REMOVE, 32'h5, 32'h1);
    send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_INSERT, 32'h0, 32'h0);
    send(OP_INSERT, 32'h8000_0000, 32'h1234);
    send(OP_INSERT, 32'h0, 32'h7);
    send(OP_LOC, 32'h0, 32'h0);
    send(OP_LOC, 32'hFFFF_FFFF, 32'h0);
    send(OP_ID, 32'h0, 32'hFFFF_FFFF);
    send(OP_ID, 32'h0, 32'h4321);
    send(OP_EDIT, 32'h8000_0000, 32'hFFFF_FFFF);
    send(OP_ID, 32'h0, 32'hFFFF_FFFF);
    send(3'd5, 32'h0, 32'h0);
    send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_REMOVE, 32'h0, 32'h0);
    send(OP_REMOVE, 32'h0, 32'h0);
    send(OP_LOC, 32'h8000_0000, 32'h0);
    send(OP_REMOVE, 32'h8000_0000, 32'h0);
    send(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);

    // Random phases; fill phases push the table to full and past it.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 1) begin
        n = Cap + 6;
        for (int i = 0; i < n; i++) begin
          send(OP_INSERT, $urandom(), id_pool[$urandom_range(0, 7)]);
          if (i >= Cap) hits_full++;
        end
        for (int i = 0; i < 20; i++) begin
          op = $urandom_range(0, 7);
          send(op[2:0], $urandom_range(0, 1) ? 32'h0 : $urandom(), id_pool[$urandom_range(0, 7)]);
        end
        for (int i = 0; i < Cap + 4; i++) send(OP_REMOVE, pick_loc(), 32'h0);
      end else begin
        for (int i = 0; i < 270; i++) begin
          op = $urandom_range(0, 99);
          k = pick_loc();
          if (op < 30) send(OP_INSERT, k, id_pool[$urandom_range(0, 7)]);
          else if (op < 45) send(OP_EDIT, k, id_pool[$urandom_range(0, 7)]);
          else if (op < 62) send(OP_REMOVE, k, 32'h0);
          else if (op < 80) send(OP_LOC, k, 32'h0);
          else if (op < 95) send(OP_ID, k, $urandom_range(0, 3) ? id_pool[$urandom_range(0, 7)]
                                              : $urandom());
          else send(3'($urandom_range(5, 7)), k, $urandom());
        end
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (2 * Cap + 20) @(posedge clk);
    $display("sent %0d operation items incl. fill-to-full phases; %0d inserts past capacity",
             sent, hits_full);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_sorted_keyed_record_table: clean");
    end else begin
      $display("tb_sorted_keyed_record_table: errors");
    end
    $finish;
  end
endmodule
